// ===== rtl/block_free_list_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Block free-list allocator assertion macros
// Shorthand for clocked implication checks; clk and rst_n come from the
// module that expands them.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFLA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFLA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bfla_pkg.sv =====
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared constants, types and link conversion helpers for the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfla_pkg;

    localparam int BLOCK_COUNT = 4096;
    localparam int IDX_W       = $clog2(BLOCK_COUNT);
    localparam int LINK_W      = IDX_W + 1;
    localparam int STEP_W      = $clog2(BLOCK_COUNT + 1);
    localparam int FIELD_W     = 13;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_SETLINK = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_NULL    = 2'd2;
    localparam logic [1:0] STAT_OVERRUN = 2'd3;

    // link: msb set means chain end / null
    typedef logic [LINK_W-1:0] link_t;

    localparam link_t LINK_NIL = {1'b1, {IDX_W{1'b0}}};

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        link_t             wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] block_id;
        logic [1:0]         status;
        logic [FIELD_W-1:0] free_head;
    } result_t;

    // negative or out-of-range field values become null
    function automatic link_t field_to_link(logic [FIELD_W-1:0] raw);
        logic [31:0] wide;
        wide = 32'(raw);
        if (raw[FIELD_W-1] || (wide >= 32'(BLOCK_COUNT)))
            return LINK_NIL;
        return {1'b0, wide[IDX_W-1:0]};
    endfunction

    function automatic logic [FIELD_W-1:0] link_to_field(link_t l);
        logic [31:0] wide;
        wide = 32'(l[IDX_W-1:0]);
        if (l[IDX_W])
            return {FIELD_W{1'b1}};
        return wide[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/bfla_link_mem.sv =====
// ----------------------------------------------------------------------------
// bfla_link_mem
// Next-link table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfla_link_mem (
    input  logic              clk,
    input  bfla_pkg::mem_req_t req,
    output bfla_pkg::link_t   rdata
);
    import bfla_pkg::*;

    link_t link_mem [BLOCK_COUNT];
    link_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            link_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= link_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfla_ctrl
// Request sequencer: table init sweep, allocate pop, release chain walk
// (one link check per cycle through the table read port) and set-link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_free_list_allocator_defines.svh"

module bfla_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_req,
    input  logic [bfla_pkg::FIELD_W-1:0]   in_block,
    input  logic [bfla_pkg::FIELD_W-1:0]   in_link,
    input  logic                           out_free,
    output bfla_pkg::mem_req_t             mem_req,
    input  bfla_pkg::link_t                mem_rdata,
    output bfla_pkg::result_t              result
);
    import bfla_pkg::*;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;
    localparam logic [1:0] ST_WALK  = 2'd3;

    logic [1:0]        state_reg,    state_next;
    logic [IDX_W-1:0]  init_cnt_reg, init_cnt_next;
    link_t             head_reg,     head_next;
    link_t             chain_reg,    chain_next;
    logic [IDX_W-1:0]  cur_reg,      cur_next;
    logic [STEP_W-1:0] step_reg,     step_next;

    link_t blk;
    link_t lnk;
    logic  accept;

    assign blk      = field_to_link(in_block);
    assign lnk      = field_to_link(in_link);
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        head_next        = head_reg;
        chain_next       = chain_reg;
        cur_next         = cur_reg;
        step_next        = step_reg;

        mem_req.we       = 1'b0;
        mem_req.waddr    = cur_reg;
        mem_req.wdata    = LINK_NIL;
        mem_req.raddr    = head_reg[IDX_W-1:0];

        result.valid     = 1'b0;
        result.block_id  = {FIELD_W{1'b1}};
        result.status    = STAT_OK;
        result.free_head = link_to_field(head_reg);

        unique case (state_reg)
            ST_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = init_cnt_reg;
                if (init_cnt_reg == IDX_W'(BLOCK_COUNT - 1))
                begin
                    mem_req.wdata = LINK_NIL;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    mem_req.wdata = {1'b0, init_cnt_reg + 1'b1};
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                // prefetch the link needed first: chain head for release, free head otherwise
                if (in_valid && (in_req == REQ_RELEASE))
                    mem_req.raddr = blk[IDX_W-1:0];
                if (accept)
                begin
                    unique case (in_req)
                        REQ_ALLOC:
                        begin
                            if (head_reg[IDX_W])
                            begin
                                result.valid  = 1'b1;
                                result.status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_ALLOC;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (blk[IDX_W])
                            begin
                                result.valid  = 1'b1;
                                result.status = STAT_NULL;
                            end
                            else
                            begin
                                chain_next = blk;
                                cur_next   = blk[IDX_W-1:0];
                                step_next  = '0;
                                state_next = ST_WALK;
                            end
                        end
                        REQ_SETLINK:
                        begin
                            result.valid = 1'b1;
                            if (blk[IDX_W])
                            begin
                                result.status = STAT_NULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = blk[IDX_W-1:0];
                                mem_req.wdata = lnk;
                            end
                        end
                        default:
                        begin
                            result.valid = 1'b1;
                        end
                    endcase
                end
            end

            ST_ALLOC:
            begin
                // mem_rdata holds the link of the old head
                mem_req.we       = 1'b1;
                mem_req.waddr    = head_reg[IDX_W-1:0];
                mem_req.wdata    = LINK_NIL;
                head_next        = mem_rdata;
                result.valid     = 1'b1;
                result.block_id  = link_to_field(head_reg);
                result.free_head = link_to_field(mem_rdata);
                state_next       = ST_IDLE;
            end

            ST_WALK:
            begin
                // mem_rdata holds the link of cur_reg
                if (mem_rdata[IDX_W])
                begin
                    mem_req.we       = 1'b1;
                    mem_req.waddr    = cur_reg;
                    mem_req.wdata    = head_reg;
                    head_next        = chain_reg;
                    result.valid     = 1'b1;
                    result.free_head = link_to_field(chain_reg);
                    state_next       = ST_IDLE;
                end
                else if (step_reg == STEP_W'(BLOCK_COUNT))
                begin
                    result.valid  = 1'b1;
                    result.status = STAT_OVERRUN;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    mem_req.raddr = mem_rdata[IDX_W-1:0];
                    cur_next      = mem_rdata[IDX_W-1:0];
                    step_next     = step_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            head_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        cur_reg   <= cur_next;
        step_reg  <= step_next;
    end

    `BFLA_ASSERT_IMP(a_ready_only_idle, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `BFLA_ASSERT_IMP(a_result_has_room, result.valid, out_free, "result with output full")
    `BFLA_ASSERT_IMP(a_walk_bounded, state_reg == ST_WALK, step_reg <= STEP_W'(BLOCK_COUNT), "walk step overflow")
    `BFLA_ASSERT_NXT(a_alloc_one_cycle, state_reg == ST_ALLOC, state_reg == ST_IDLE, "allocate did not finish")
    `BFLA_ASSERT_IMP(a_no_write_on_read_idle, (state_reg == ST_IDLE) && !accept, !mem_req.we, "table write while idle")

endmodule

// ===== rtl/block_free_list_allocator.sv =====
// Set-link, empty allocate, null release and unused kinds answer straight from idle; allocate adds
// the pop state; release walks the chain, one link read per cycle from the single table read port.
// Overrun on a cyclic chain is reported once the walk step counter reaches BLOCK_COUNT.
// Throughput: one item at a time; the next item is taken once the result slot is free.
// Reset: rst_n async low; then an init sweep builds chain 0..N-1 (s_tready low).
// ----------------------------------------------------------------------------
// block_free_list_allocator
// Linked free-list allocator for fixed-size storage blocks, stream ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_free_list_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // block [12:0], link_to [25:13], zero [31:26]
    input  logic [1:0]  s_tuser,   // req_type [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // block_id [12:0], free_head [25:13], zero [31:26]
    output logic [1:0]  m_tuser    // status [1:0]
);
    import bfla_pkg::*;

    mem_req_t mem_req;
    link_t    mem_rdata;
    result_t  result;
    logic     out_free;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_block_reg;
    logic [1:0]         out_status_reg;
    logic [FIELD_W-1:0] out_head_reg;

    assign out_free = !out_valid_reg || m_tready;

    bfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_block  (s_tdata[FIELD_W-1:0]),
        .in_link   (s_tdata[2*FIELD_W-1:FIELD_W]),
        .out_free  (out_free),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .result    (result)
    );

    bfla_link_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_block_reg  <= result.block_id;
            out_status_reg <= result.status;
            out_head_reg   <= result.free_head;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_head_reg, out_block_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: block free-list allocator testbench
// Drives allocate, release and set-link requests into the stream port and
// checks every result beat against a cycle-free model of the link table and
// free head. A directed part covers null blocks, the unused kind, an empty
// list and a cyclic chain; random traffic follows under three idle mixes.
// ----------------------------------------------------------------------------

module tb;
    import bfla_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         NIL_BLK     = -1;
    localparam int         SHORT_WALK  = 64;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         DRAIN_WAIT  = 20;
    localparam int         PHASE_ITEMS = 250;

    typedef struct packed {
        logic [12:0] block_id;
        logic [1:0]  status;
        logic [12:0] free_head;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // block [12:0], link_to [25:13], zero [31:26]
    logic [1:0]  s_tuser = '0;   // req_type [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // block_id [12:0], free_head [25:13], zero [31:26]
    logic [1:0]  m_tuser;        // status [1:0]

    // model state
    int link_tbl [BLOCK_COUNT];
    int head_blk;

    alloc_result_t pending_results[$];
    int            held_blocks[$];

    int send_idle_pct = 10;
    int recv_idle_pct = 63;
    int long_walks_left = 6;
    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int status_seen [4];

    block_free_list_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic int field_index(logic [12:0] raw);
        if (raw[12] || int'(raw) >= BLOCK_COUNT)
            return NIL_BLK;
        return int'(raw);
    endfunction

    // follows links from start; returns the tail, or nil when the chain
    // never ends within BLOCK_COUNT hops
    function automatic int walk_chain(int start, output int steps);
        int cur;
        cur = start;
        steps = 0;
        while (steps < BLOCK_COUNT && link_tbl[cur] >= 0)
        begin
            cur = link_tbl[cur];
            steps++;
        end
        return (link_tbl[cur] >= 0) ? NIL_BLK : cur;
    endfunction

    function automatic alloc_result_t apply_request(logic [1:0] req, logic [12:0] blk_raw,
                                                    logic [12:0] lnk_raw);
        alloc_result_t res;
        int blk;
        int lnk;
        int given;
        int tail;
        int steps;
        blk = field_index(blk_raw);
        lnk = field_index(lnk_raw);
        given = NIL_BLK;
        res.status = STAT_OK;
        case (req)
            REQ_ALLOC:
                if (head_blk < 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    given = head_blk;
                    head_blk = link_tbl[given];
                    link_tbl[given] = NIL_BLK;
                end
            REQ_RELEASE:
                if (blk < 0)
                    res.status = STAT_NULL;
                else
                begin
                    tail = walk_chain(blk, steps);
                    if (tail < 0)
                        res.status = STAT_OVERRUN;
                    else
                    begin
                        link_tbl[tail] = head_blk;
                        head_blk = blk;
                    end
                end
            REQ_SETLINK:
                if (blk < 0)
                    res.status = STAT_NULL;
                else
                    link_tbl[blk] = lnk;
            default: ;
        endcase
        res.block_id = 13'(given);
        res.free_head = 13'(head_blk);
        status_seen[res.status]++;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic [12:0] rand13();
        return 13'($urandom_range(0, 8191));
    endfunction

    function automatic logic [12:0] rand_nil();
        return 13'h1000 | 13'($urandom_range(0, 4095));
    endfunction

    task automatic send_req(input logic [1:0] req, input logic [12:0] blk,
                            input logic [12:0] lnk, output alloc_result_t res);
        int idx;
        int steps;
        int tail;
        idx = field_index(blk);
        // long walks are slow; only six are let through, the rest become allocates
        if (req == REQ_RELEASE && idx >= 0)
        begin
            tail = walk_chain(idx, steps);
            if (steps > SHORT_WALK)
            begin
                if (long_walks_left > 0)
                    long_walks_left--;
                else
                    req = REQ_ALLOC;
            end
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        res = apply_request(req, blk, lnk);
        pending_results.push_back(res);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, lnk, blk};
        s_tuser  <= req;
        items_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                 results_checked, what, got, exp);
    endtask

    always @(posedge clk)
    begin
        alloc_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                log_mismatch("unexpected beat", m_tdata, 32'd0);
            else
            begin
                exp = pending_results.pop_front();
                if (m_tdata[12:0] !== exp.block_id)
                    log_mismatch("block_id", 32'(m_tdata[12:0]), 32'(exp.block_id));
                if (m_tuser !== exp.status)
                    log_mismatch("status", 32'(m_tuser), 32'(exp.status));
                if (m_tdata[25:13] !== exp.free_head)
                    log_mismatch("free_head", 32'(m_tdata[25:13]), 32'(exp.free_head));
                if (m_tdata[31:26] !== 6'b0)
                    log_mismatch("pad bits", 32'(m_tdata[31:26]), 32'd0);
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_alloc_and_release_chain();
        alloc_result_t a;
        alloc_result_t b;
        alloc_result_t c;
        alloc_result_t r;
        send_req(REQ_ALLOC, 13'h0000, 13'h1FFF, a);
        send_req(REQ_ALLOC, 13'h1FFF, 13'h0000, b);
        send_req(REQ_ALLOC, 13'h0FFF, 13'h1000, c);
        send_req(REQ_SETLINK, a.block_id, b.block_id, r);
        send_req(REQ_SETLINK, b.block_id, c.block_id, r);
        send_req(REQ_RELEASE, a.block_id, rand13(), r);
        // cut the free list to a small pool; the rest stays orphaned
        send_req(REQ_SETLINK, 13'd31, 13'h1FFF, r);
    endtask

    task automatic test_null_and_unused();
        alloc_result_t r;
        send_req(REQ_RELEASE, 13'h1FFF, 13'h0000, r);
        send_req(REQ_RELEASE, 13'h1000, 13'h0FFF, r);
        send_req(REQ_SETLINK, 13'h1ABC, 13'd5, r);
        send_req(REQ_UNUSED, 13'h1FFF, 13'h0FFF, r);
        send_req(REQ_UNUSED, 13'h0000, 13'h0000, r);
    endtask

    task automatic test_top_block();
        alloc_result_t r;
        send_req(REQ_SETLINK, 13'd4000, 13'h0FFF, r);
        send_req(REQ_RELEASE, 13'h0FFF, 13'h1FFF, r);
        send_req(REQ_ALLOC, 13'h0AAA, 13'h1555, r);
    endtask

    task automatic test_walk_overrun();
        alloc_result_t r;
        // top block is held here; a self link makes its chain endless
        send_req(REQ_SETLINK, 13'h0FFF, 13'h0FFF, r);
        send_req(REQ_RELEASE, 13'h0FFF, 13'h0000, r);
        send_req(REQ_SETLINK, 13'h0FFF, 13'h1555, r);
        send_req(REQ_RELEASE, 13'h0FFF, 13'h0000, r);
    endtask

    task automatic test_empty_list();
        alloc_result_t r;
        int hd;
        int rest;
        hd = head_blk;
        rest = link_tbl[hd];
        send_req(REQ_SETLINK, 13'(hd), rand_nil(), r);
        send_req(REQ_ALLOC, rand13(), rand13(), r);
        send_req(REQ_ALLOC, rand13(), rand13(), r);
        send_req(REQ_RELEASE, 13'h1FFF, rand13(), r);
        if (rest >= 0)
            send_req(REQ_RELEASE, 13'(rest), rand13(), r);
        send_req(REQ_RELEASE, 13'(hd), rand13(), r);
    endtask

    // allocate a few blocks, link them, then mostly hand the chain back
    task automatic chain_burst();
        alloc_result_t r;
        int ids[$];
        int k;
        int pick;
        k = $urandom_range(1, 5);
        repeat (k)
        begin
            send_req(REQ_ALLOC, rand13(), rand13(), r);
            if (r.status == STAT_OK)
                ids.push_back(int'(r.block_id));
        end
        for (int i = 0; i + 1 < ids.size(); i++)
            send_req(REQ_SETLINK, 13'(ids[i]), 13'(ids[i + 1]), r);
        if (ids.size() == 0)
            return;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            send_req(REQ_RELEASE, 13'(ids[0]), rand13(), r);
        else if (pick < 8)
            held_blocks.push_back(ids[0]);
        else if (pick < 9)
        begin
            send_req(REQ_SETLINK, 13'(ids[ids.size() - 1]), rand_nil(), r);
            send_req(REQ_RELEASE, 13'(ids[ids.size() - 1]), rand13(), r);
            held_blocks.push_back(ids[0]);
        end
        else
        begin
            // closed loop: release overruns unless the walk budget is spent
            send_req(REQ_SETLINK, 13'(ids[ids.size() - 1]), 13'(ids[0]), r);
            send_req(REQ_RELEASE, 13'(ids[0]), rand13(), r);
            send_req(REQ_SETLINK, 13'(ids[ids.size() - 1]), rand_nil(), r);
            held_blocks.push_back(ids[0]);
        end
    endtask

    task automatic single_request();
        alloc_result_t r;
        logic [12:0] blk;
        logic [12:0] lnk;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_req(REQ_ALLOC, rand13(), rand13(), r);
            if (r.status == STAT_OK)
                held_blocks.push_back(int'(r.block_id));
        end
        else if (pick < 50)
        begin
            if (held_blocks.size() != 0)
                blk = 13'(held_blocks.pop_front());
            else
                blk = 13'($urandom_range(0, 31));
            send_req(REQ_RELEASE, blk, rand13(), r);
        end
        else if (pick < 65)
        begin
            blk = ($urandom_range(0, 1) && held_blocks.size() != 0)
                  ? 13'(held_blocks[$urandom_range(0, held_blocks.size() - 1)])
                  : 13'($urandom_range(0, 31));
            lnk = $urandom_range(0, 2) ? 13'($urandom_range(0, 31)) : rand_nil();
            send_req(REQ_SETLINK, blk, lnk, r);
        end
        else if (pick < 75)
            send_req(2'($urandom_range(1, 2)), rand_nil(), rand13(), r);
        else
            send_req(2'($urandom_range(0, 3)), rand13(), rand13(), r);
    endtask

    task automatic test_random_traffic(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 60)
                chain_burst();
            else
                single_request();
        end
    endtask

    initial
    begin
        for (int i = 0; i < BLOCK_COUNT; i++)
            link_tbl[i] = (i + 1 < BLOCK_COUNT) ? i + 1 : NIL_BLK;
        head_blk = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 63;
        test_alloc_and_release_chain();
        test_null_and_unused();
        test_top_block();
        test_walk_overrun();
        test_empty_list();
        test_random_traffic(PHASE_ITEMS);

        send_idle_pct = 63;
        recv_idle_pct = 10;
        test_random_traffic(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d requests, checked %0d result beats in %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("Status mix: ok %0d, empty %0d, null %0d, overrun %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY],
                 status_seen[STAT_NULL], status_seen[STAT_OVERRUN]);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
